>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helpers for the port-level checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define STB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define STB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// shared types and constants of the soft timer bank
// ----------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

    // command codes on the slave-side tuser
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
    localparam logic [OP_W-1:0] OP_DESTROY = 3'd2;
    localparam logic [OP_W-1:0] OP_START   = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd4;
    localparam logic [OP_W-1:0] OP_CHECK   = 3'd5;

    // result kinds on the master-side tuser
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_CREATED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FAILED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd2;

    // slot flag bit positions
    localparam int FLAGS_W      = 3;
    localparam int FLAG_ACTIVE  = 0;
    localparam int FLAG_RUNNING = 1;
    localparam int FLAG_REPEAT  = 2;

    localparam int TICK_W      = 32;
    localparam int SLOT_W      = 4;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;
    localparam int MAX_RESULTS = 16;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic tick_inc;
        logic flag_destroy;
        logic flag_stop;
        logic addr_slot;
        logic ram_rd;
        logic idx_clr;
        logic idx_inc;
        logic div_start;
        logic create_wr;
        logic arm_wr;
        logic fire;
        logic pend_fail;
        logic emit_last;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            slot_ok;
        logic            idx_free;
        logic            idx_last;
        logic            div_busy;
        logic            out_free;
        logic            pend_valid;
        logic            hit;
        logic            cap_full;
    } ctl_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/stb_ram.sv
// ----------------------------------------------------------------------------
// stb_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module stb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/stb_div.sv
// ----------------------------------------------------------------------------
// stb_div
// division by a fixed divisor as a reciprocal multiply, one half of the
// dividend per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module stb_div #(
    parameter int DIVISOR = 100
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [stb_pkg::TICK_W-1:0]  dividend,
    output logic                             busy,
    output logic      [stb_pkg::TICK_W-1:0]  quotient
);

    // quotient = (dividend * RECIP) >> (TICK_W + SHIFT), exact for every dividend
    localparam int SHIFT   = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
    localparam int RECIP_W = stb_pkg::TICK_W + 1;
    localparam int HALF_W  = stb_pkg::TICK_W / 2;
    localparam int PART_W  = HALF_W + RECIP_W;
    localparam int ACC_W   = stb_pkg::TICK_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << (stb_pkg::TICK_W + SHIFT)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    logic [stb_pkg::TICK_W-1:0] num_reg,   num_next;
    logic [ACC_W-1:0]           acc_reg,   acc_next;
    logic                       phase_reg, phase_next;
    logic                       busy_reg,  busy_next;
    logic [HALF_W-1:0]          half;
    logic [PART_W-1:0]          part;

    always_comb
    begin
        // low half first, then the high half weighted by 2^HALF_W
        half       = phase_reg ? num_reg[stb_pkg::TICK_W-1:HALF_W] : num_reg[HALF_W-1:0];
        part       = PART_W'(half) * PART_W'(RECIP);
        num_next   = num_reg;
        acc_next   = acc_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        if (start)
        begin
            num_next   = dividend;
            acc_next   = '0;
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (phase_reg)
            begin
                acc_next  = acc_reg + (ACC_W'(part) << HALF_W);
                busy_next = 1'b0;
            end
            else
            begin
                acc_next = ACC_W'(part);
            end
            phase_next = !phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        acc_reg <= acc_next;
    end

    assign busy     = busy_reg;
    assign quotient = stb_pkg::TICK_W'(acc_reg >> (stb_pkg::TICK_W + SHIFT));

endmodule

`default_nettype wire

>>> rtl/core/stb_dp.sv
// ----------------------------------------------------------------------------
// stb_dp
// datapath: command register, tick counter, slot flags, slot memories,
// divider, pending result and output register
// ----------------------------------------------------------------------------
`default_nettype none

module stb_dp #(
    parameter int SLOT_COUNT  = 16,
    parameter int MS_PER_TICK = 100
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire stb_pkg::ctl_cmd_t                 cmd,
    output stb_pkg::ctl_sts_t                      sts,
    input  wire logic [stb_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic [stb_pkg::OP_W-1:0]          s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [stb_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic      [stb_pkg::KIND_W-1:0]        m_tuser,
    output logic                                   m_tlast
);

    localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W   = $clog2(stb_pkg::MAX_RESULTS + 1);
    localparam int RANGE_W = 8;

    // captured command
    logic [stb_pkg::OP_W-1:0]   op_reg;
    logic [stb_pkg::TICK_W-1:0] ivl_reg;
    logic                       start_now_reg;
    logic                       repeat_reg;
    logic [stb_pkg::SLOT_W-1:0] slot_reg;

    logic [stb_pkg::TICK_W-1:0]  tick_reg,     tick_next;
    logic [stb_pkg::FLAGS_W-1:0] flags_reg [SLOT_COUNT];
    logic [stb_pkg::FLAGS_W-1:0] flags_next [SLOT_COUNT];
    logic [IDX_W-1:0]            idx_reg,      idx_next;
    logic [CNT_W-1:0]            fire_cnt_reg, fire_cnt_next;

    logic                        pend_valid_reg, pend_valid_next;
    logic [stb_pkg::KIND_W-1:0]  pend_kind_reg,  pend_kind_next;
    logic [stb_pkg::SLOT_W-1:0]  pend_idx_reg,   pend_idx_next;

    logic                        out_valid_reg,  out_valid_next;
    logic [stb_pkg::KIND_W-1:0]  out_kind_reg,   out_kind_next;
    logic [stb_pkg::SLOT_W-1:0]  out_idx_reg,    out_idx_next;
    logic                        out_last_reg,   out_last_next;
    logic                        out_load;

    logic [IDX_W-1:0]            slot_idx;
    logic [IDX_W-1:0]            ram_addr;
    logic [stb_pkg::FLAGS_W-1:0] cur_flags;
    logic [stb_pkg::TICK_W-1:0]  period_rd;
    logic [stb_pkg::TICK_W-1:0]  deadline_rd;
    logic [stb_pkg::TICK_W-1:0]  quotient;
    logic                        div_busy;
    logic                        dl_we;
    logic [stb_pkg::TICK_W-1:0]  dl_wdata;

    assign slot_idx  = IDX_W'(slot_reg);
    assign ram_addr  = cmd.addr_slot ? slot_idx : idx_reg;
    assign cur_flags = flags_reg[idx_reg];

    // deadline is rewritten on create with start, on start and on a periodic fire
    assign dl_we    = (cmd.create_wr && start_now_reg) || cmd.arm_wr
                      || (cmd.fire && cur_flags[stb_pkg::FLAG_REPEAT]);
    assign dl_wdata = tick_reg + (cmd.create_wr ? quotient : period_rd);

    stb_div #(
        .DIVISOR (MS_PER_TICK)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (ivl_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // period in ticks, written once per create
    stb_ram #(
        .WIDTH (stb_pkg::TICK_W),
        .DEPTH (SLOT_COUNT)
    ) u_period_ram (
        .clk   (clk),
        .we    (cmd.create_wr),
        .waddr (ram_addr),
        .wdata (quotient),
        .re    (cmd.ram_rd),
        .raddr (ram_addr),
        .rdata (period_rd)
    );

    stb_ram #(
        .WIDTH (stb_pkg::TICK_W),
        .DEPTH (SLOT_COUNT)
    ) u_deadline_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (ram_addr),
        .wdata (dl_wdata),
        .re    (cmd.ram_rd),
        .raddr (ram_addr),
        .rdata (deadline_rd)
    );

    always_comb
    begin
        flags_next = flags_reg;
        if (cmd.flag_destroy)
        begin
            flags_next[slot_idx][stb_pkg::FLAG_ACTIVE] = 1'b0;
        end
        if (cmd.flag_stop)
        begin
            flags_next[slot_idx][stb_pkg::FLAG_RUNNING] = 1'b0;
        end
        if (cmd.arm_wr)
        begin
            flags_next[slot_idx][stb_pkg::FLAG_RUNNING] = 1'b1;
        end
        if (cmd.create_wr)
        begin
            flags_next[idx_reg] = {repeat_reg, start_now_reg, 1'b1};
        end
        if (cmd.fire && !cur_flags[stb_pkg::FLAG_REPEAT])
        begin
            flags_next[idx_reg][stb_pkg::FLAG_RUNNING] = 1'b0;
        end
    end

    always_comb
    begin
        tick_next     = cmd.tick_inc ? tick_reg + stb_pkg::TICK_W'(1) : tick_reg;
        idx_next      = idx_reg;
        fire_cnt_next = fire_cnt_reg;
        if (cmd.idx_clr)
        begin
            idx_next      = '0;
            fire_cnt_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (cmd.fire)
        begin
            fire_cnt_next = fire_cnt_reg + CNT_W'(1);
        end
    end

    // pending result: held back until it is known whether another follows
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_idx_next   = pend_idx_reg;
        if (cmd.create_wr)
        begin
            pend_valid_next = 1'b1;
            pend_kind_next  = stb_pkg::KIND_CREATED;
            pend_idx_next   = stb_pkg::SLOT_W'(idx_reg);
        end
        else if (cmd.pend_fail)
        begin
            pend_valid_next = 1'b1;
            pend_kind_next  = stb_pkg::KIND_FAILED;
            pend_idx_next   = '0;
        end
        else if (cmd.fire)
        begin
            pend_valid_next = 1'b1;
            pend_kind_next  = stb_pkg::KIND_FIRED;
            pend_idx_next   = stb_pkg::SLOT_W'(idx_reg);
        end
        else if (cmd.emit_last)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_load       = (cmd.fire && pend_valid_reg) || cmd.emit_last;
        out_kind_next  = out_kind_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = pend_kind_reg;
            out_idx_next   = pend_idx_reg;
            out_last_next  = cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            idx_reg        <= '0;
            fire_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                flags_reg[i] <= '0;
            end
        end
        else
        begin
            tick_reg       <= tick_next;
            idx_reg        <= idx_next;
            fire_cnt_reg   <= fire_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            flags_reg      <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= s_tuser;
            ivl_reg       <= s_tdata[31:0];
            start_now_reg <= s_tdata[32];
            repeat_reg    <= s_tdata[33];
            slot_reg      <= s_tdata[37:34];
        end
        pend_kind_reg <= pend_kind_next;
        pend_idx_reg  <= pend_idx_next;
        out_kind_reg  <= out_kind_next;
        out_idx_reg   <= out_idx_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        sts.op         = op_reg;
        sts.slot_ok    = (RANGE_W'(slot_reg) < RANGE_W'(SLOT_COUNT));
        sts.idx_free   = !cur_flags[stb_pkg::FLAG_ACTIVE];
        sts.idx_last   = (idx_reg == IDX_W'(SLOT_COUNT - 1));
        sts.div_busy   = div_busy;
        sts.out_free   = !out_valid_reg || m_tready;
        sts.pend_valid = pend_valid_reg;
        sts.hit        = cur_flags[stb_pkg::FLAG_ACTIVE] && cur_flags[stb_pkg::FLAG_RUNNING]
                         && ($signed(tick_reg) >= $signed(deadline_rd));
        sts.cap_full   = (fire_cnt_reg == CNT_W'(stb_pkg::MAX_RESULTS));
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = stb_pkg::M_TDATA_W'(out_idx_reg);
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/core/stb_ctrl.sv
// ----------------------------------------------------------------------------
// stb_ctrl
// command sequencer: decode, free-slot search, slot scan and result flush
// ----------------------------------------------------------------------------
`default_nettype none

module stb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire stb_pkg::ctl_sts_t sts,
    output stb_pkg::ctl_cmd_t      cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_DECODE  = 10'b00_0000_0010,
        S_FIND    = 10'b00_0000_0100,
        S_DIV     = 10'b00_0000_1000,
        S_CREATE  = 10'b00_0001_0000,
        S_ARM     = 10'b00_0010_0000,
        S_CHK_RD  = 10'b00_0100_0000,
        S_CHK_EV  = 10'b00_1000_0000,
        S_CHK_END = 10'b01_0000_0000,
        S_FLUSH   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                unique case (sts.op)
                    stb_pkg::OP_TICK:    cmd.tick_inc     = 1'b1;
                    stb_pkg::OP_DESTROY: cmd.flag_destroy = sts.slot_ok;
                    stb_pkg::OP_STOP:    cmd.flag_stop    = sts.slot_ok;
                    stb_pkg::OP_CREATE:
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_FIND;
                    end
                    stb_pkg::OP_START:
                    begin
                        if (sts.slot_ok)
                        begin
                            cmd.addr_slot = 1'b1;
                            cmd.ram_rd    = 1'b1;
                            state_next    = S_ARM;
                        end
                    end
                    stb_pkg::OP_CHECK:
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_CHK_RD;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_FIND:
            begin
                priority if (sts.idx_free)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (sts.idx_last)
                begin
                    cmd.pend_fail = 1'b1;
                    state_next    = S_FLUSH;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_CREATE;
                end
            end
            S_CREATE:
            begin
                cmd.create_wr = 1'b1;
                state_next    = S_FLUSH;
            end
            S_ARM:
            begin
                cmd.addr_slot = 1'b1;
                cmd.arm_wr    = 1'b1;
                state_next    = S_IDLE;
            end
            S_CHK_RD:
            begin
                if (sts.cap_full)
                begin
                    state_next = S_CHK_END;
                end
                else
                begin
                    cmd.ram_rd = 1'b1;
                    state_next = S_CHK_EV;
                end
            end
            S_CHK_EV:
            begin
                // a fire pushes the earlier pending result out, so wait for room
                if (!(sts.hit && sts.pend_valid && !sts.out_free))
                begin
                    cmd.fire = sts.hit;
                    if (sts.idx_last)
                    begin
                        state_next = S_CHK_END;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_CHK_RD;
                    end
                end
            end
            S_CHK_END:
            begin
                state_next = sts.pend_valid ? S_FLUSH : S_IDLE;
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/soft_timer_bank_top.sv
// steps: tick, destroy and stop finish in decode; start reads the memories, then arms
// create searches the slots (up to SLOT_COUNT), runs the two-step reciprocal multiply,
//   writes the slot and loads the output register; a failed create skips the multiply
// check scans each slot with one ram read and one compare, then loads the last result,
//   if any; one command at a time, the next taken back in idle, output stalls hold it up
// reset: tick counter and all slot flags clear at once, slot memories need no clearing pass
// ----------------------------------------------------------------------------
// soft_timer_bank_top
// bank of software-style timer slots driven by a tick counter
// ----------------------------------------------------------------------------
`default_nettype none

module soft_timer_bank_top #(
    parameter int SLOT_COUNT  = 16,  // number of timer slots, 1 to 16
    parameter int MS_PER_TICK = 100  // milliseconds per tick, 1 to 1000
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // interval_ms[31:0], start_now, repeat_mode,
                                        // slot[3:0], zero pad
    input  wire logic [2:0]  s_tuser,   // opcode
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // slot_index[3:0], zero pad
    output logic      [1:0]  m_tuser,   // kind
    output logic             m_tlast    // final result of the command
);

    // command and status between the sequencer and the datapath
    stb_pkg::ctl_cmd_t cmd;
    stb_pkg::ctl_sts_t sts;

    // sequencer: one-hot state machine, owns the slave-side ready
    stb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: counter, flags, period and deadline memories, divider,
    // pending result held back for tlast and the output register
    stb_dp #(
        .SLOT_COUNT  (SLOT_COUNT),
        .MS_PER_TICK (MS_PER_TICK)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/core/stb_chk.sv
// ----------------------------------------------------------------------------
// stb_chk
// port-level checks of the soft timer bank, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stb_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser,
    input wire logic       m_tlast
);

    // a stalled result holds
    `STB_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // one command at a time: ready drops after every accepted command
    `STB_ASSERT(a_one_cmd, s_tvalid && s_tready |=> !s_tready, "command accepted while busy")

    // create results stand alone and always close their command
    `STB_ASSERT(a_create_last, m_tvalid && m_tuser != stb_pkg::KIND_FIRED |-> m_tlast, "create result without tlast")

    // a failed create reports slot zero
    `STB_ASSERT(a_fail_zero, m_tvalid && m_tuser == stb_pkg::KIND_FAILED |-> m_tdata == 8'd0, "failed create with nonzero slot")

    // nothing offered while in reset
    `STB_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind soft_timer_bank_top stb_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> bench/stb_checker.sv
// ----------------------------------------------------------------------------
// stb_checker
// watches both streams of the soft timer bank, predicts every result from
// the accepted commands and compares what comes out, in order
// ----------------------------------------------------------------------------
module stb_checker
    import stb_pkg::*;
#(
    parameter int SLOT_COUNT  = 16,
    parameter int MS_PER_TICK = 100
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // interval_ms[31:0], start_now, repeat_mode, slot[3:0]
    input  logic [2:0]  s_tuser,   // opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // slot_index[3:0]
    input  logic [1:0]  m_tuser,   // kind
    input  logic        m_tlast,
    output int          pending,
    output int          fails
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } timer_event_t;

    timer_event_t      events_due[$];
    timer_event_t      head;
    logic [TICK_W-1:0] tick_ctr;
    logic [FLAGS_W-1:0] flags [SLOT_COUNT];
    logic [31:0]       period_ms [SLOT_COUNT];
    logic [TICK_W-1:0] due_tick [SLOT_COUNT];

    initial
    begin
        pending = 0;
        fails   = 0;
    end

    function automatic void arm_timer(int idx);
        due_tick[idx] = tick_ctr + period_ms[idx] / 32'(MS_PER_TICK);
        flags[idx][FLAG_RUNNING] = 1'b1;
    endfunction

    function automatic void apply_command(logic [OP_W-1:0] op, logic [31:0] ivl,
                                          logic go, logic rep, logic [SLOT_W-1:0] slot);
        int           idx;
        int           hits;
        timer_event_t ev;
        case (op)
            OP_TICK:
                tick_ctr = tick_ctr + 1'b1;
            OP_CREATE:
            begin
                idx = 0;
                while (idx < SLOT_COUNT && flags[idx][FLAG_ACTIVE])
                    idx++;
                if (idx >= SLOT_COUNT)
                    events_due.push_back('{KIND_FAILED, '0, 1'b1});
                else
                begin
                    flags[idx] = '0;
                    flags[idx][FLAG_ACTIVE] = 1'b1;
                    flags[idx][FLAG_REPEAT] = rep;
                    period_ms[idx] = ivl;
                    if (go)
                        arm_timer(idx);
                    events_due.push_back('{KIND_CREATED, SLOT_W'(idx), 1'b1});
                end
            end
            OP_DESTROY:
                if (slot < SLOT_COUNT)
                    flags[slot][FLAG_ACTIVE] = 1'b0;
            OP_START:
                if (slot < SLOT_COUNT)
                    arm_timer(slot);
            OP_STOP:
                if (slot < SLOT_COUNT)
                    flags[slot][FLAG_RUNNING] = 1'b0;
            OP_CHECK:
            begin
                hits = 0;
                for (idx = 0; idx < SLOT_COUNT && hits < MAX_RESULTS; idx++)
                begin
                    if (flags[idx][FLAG_ACTIVE] && flags[idx][FLAG_RUNNING]
                        && $signed(tick_ctr) >= $signed(due_tick[idx]))
                    begin
                        flags[idx][FLAG_RUNNING] = 1'b0;
                        events_due.push_back('{KIND_FIRED, SLOT_W'(idx), 1'b0});
                        hits++;
                        if (flags[idx][FLAG_REPEAT])
                            arm_timer(idx);
                    end
                end
                // mark the final firing of this scan
                if (hits > 0)
                begin
                    ev = events_due.pop_back();
                    ev.last = 1'b1;
                    events_due.push_back(ev);
                end
            end
            default:
                ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ctr = '0;
            for (int i = 0; i < SLOT_COUNT; i++)
                flags[i] = '0;
            events_due.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (events_due.size() == 0)
                begin
                    $error("result with nothing expected: kind %0d slot_index %0d last %0b",
                           m_tuser, m_tdata[3:0], m_tlast);
                    fails++;
                end
                else
                begin
                    head = events_due.pop_front();
                    if (m_tuser !== head.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", head.kind, m_tuser);
                        fails++;
                    end
                    if (m_tdata[3:0] !== head.slot)
                    begin
                        $error("slot_index: expected %0d, actual %0d", head.slot, m_tdata[3:0]);
                        fails++;
                    end
                    if (m_tlast !== head.last)
                    begin
                        $error("last: expected %0b, actual %0b", head.last, m_tlast);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_command(s_tuser, s_tdata[31:0], s_tdata[32], s_tdata[33],
                              s_tdata[37:34]);
            pending = events_due.size();
        end
    end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// soft timer bank: directed commands covering the full bank, create failure,
// slot reuse and a sixteen-way firing, then a random command mix with short
// timers so that checks fire often; both streams idle at random
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stb_pkg::*;

    localparam int SLOTS       = 16;
    localparam int TICK_MS     = 100;
    localparam int RANDOM_CMDS = 200;
    localparam int DRAIN_WAIT  = 100;   // longer than the slowest create

    // opcodes the block has no use for
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // interval_ms[31:0], start_now, repeat_mode, slot[3:0], zero pad
    logic [2:0]  s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // slot_index[3:0], zero pad
    logic [1:0]  m_tuser;   // kind
    logic        m_tlast;
    int          pending;
    int          fails;
    int          cmd_no = 0;
    int          result_no = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    soft_timer_bank_top #(
        .SLOT_COUNT  (SLOTS),
        .MS_PER_TICK (TICK_MS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    stb_checker #(
        .SLOT_COUNT  (SLOTS),
        .MS_PER_TICK (TICK_MS)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .pending  (pending),
        .fails    (fails)
    );

    // one command transaction; valid stays high when the next follows at once
    task automatic issue_command(logic [OP_W-1:0] op, logic [31:0] ivl, logic go,
                                 logic rep, logic [SLOT_W-1:0] slot);
        int gap;
        // every 40 commands, a stretch of 8 back to back
        gap = (cmd_no % 40 < 8) ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, slot, rep, go, ivl};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        cmd_no++;
    endtask

    // result side: stall before each result, with calm stretches
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = (result_no % 32 < 8) ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            result_no++;
        end
    end

    initial
    begin
        int              useful;
        int              pick;
        logic [OP_W-1:0] op;
        logic [31:0]     ivl;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_TICK;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        issue_command(OP_TICK, '0, 1'b0, 1'b0, '0);
        // fill the whole bank; every interval below one tick so all are due at once
        for (int i = 0; i < SLOTS; i++)
            issue_command(OP_CREATE, 32'(i * 6), 1'b1, i[0], '0);
        // bank full: create must fail
        issue_command(OP_CREATE, 32'd500, 1'b1, 1'b1, '0);
        // all sixteen fire in one scan, the odd ones rearm
        issue_command(OP_CHECK, '0, 1'b0, 1'b0, '0);
        issue_command(OP_DESTROY, '0, 1'b0, 1'b0, 4'd3);
        issue_command(OP_STOP, '0, 1'b0, 1'b0, 4'd5);
        // reuse of slot 3 drops its stale repeat flag; widest interval
        issue_command(OP_CREATE, 32'hFFFF_FFFF, 1'b1, 1'b0, 4'hF);
        issue_command(OP_START, '0, 1'b0, 1'b0, 4'd2);
        issue_command(OP_SPARE_6, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'hF);
        // start on an inactive slot arms it, but it must not fire
        issue_command(OP_DESTROY, '0, 1'b0, 1'b0, 4'd7);
        issue_command(OP_START, '0, 1'b0, 1'b0, 4'd7);
        issue_command(OP_TICK, '0, 1'b0, 1'b0, '0);
        issue_command(OP_CHECK, '0, 1'b0, 1'b0, '0);

        // random part; every slot has been written by now, so any start is legal
        useful = 0;
        while (useful < RANDOM_CMDS)
        begin
            pick = $urandom_range(0, 99);
            ivl  = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 1500));
            if (pick < 30)
                op = OP_TICK;
            else if (pick < 50)
                op = OP_CHECK;
            else if (pick < 64)
                op = OP_CREATE;
            else if (pick < 75)
                op = OP_DESTROY;
            else if (pick < 87)
                op = OP_START;
            else if (pick < 96)
                op = OP_STOP;
            else
                op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
            issue_command(op, ivl, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          SLOT_W'($urandom_range(0, 15)));
            if (op != OP_SPARE_6 && op != OP_SPARE_7)
                useful++;
        end
        s_tvalid <= 1'b0;
        // let the checker take in the last command before its count is read
        @(posedge clk);

        // drain, then give the last command time to finish
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> soft_timer_bank_top.f
+incdir+rtl/core
rtl/core/stb_pkg.sv
rtl/core/stb_ram.sv
rtl/core/stb_div.sv
rtl/core/stb_dp.sv
rtl/core/stb_ctrl.sv
rtl/core/soft_timer_bank_top.sv
rtl/core/stb_chk.sv
bench/stb_checker.sv
bench/tb.sv
